@@ design/kti_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyframe track interpolator package
// Shared types, codes and a helper function for the keyframe interpolator.
// ----------------------------------------------------------------------------
package kti_pkg;

    localparam int VALUE_W  = 32;
    localparam int FRAME_W  = 16;
    localparam int POS_W    = 24;
    localparam int CFG_W    = 16;
    localparam int CFG_IX_W = 1;
    localparam int WGT_W    = 17;
    localparam int WRAW_W   = 23;

    localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EASE_LINEAR = 2'd0,
        EASE_IN     = 2'd1,
        EASE_OUT    = 2'd2,
        EASE_HOLD   = 2'd3
    } ease_t;

    typedef enum logic [CFG_IX_W-1:0] {
        REG_CYCLE_LENGTH = 1'b0,
        REG_LOOP_ENABLE  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        op_t                       op;
        logic [4:0]                element;
        logic [3:0]                property_req;
        logic signed [VALUE_W-1:0] key_value;
        logic [FRAME_W-1:0]        key_frame;
        ease_t                     key_ease;
        logic [POS_W-1:0]          position;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      valid_res;
    } out_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] val;
        logic [FRAME_W-1:0]        frame;
        ease_t                     ease;
    } key_t;

    // Clamp a raw weight to the range 0..1.0 in Q16
    function automatic logic [WGT_W-1:0] clamp_weight(input logic signed [WRAW_W-1:0] x);
        logic [WGT_W-1:0] w;
        if (x < 0)
        begin
            w = '0;
        end
        else if (x > signed'({6'd0, WGT_ONE}))
        begin
            w = WGT_ONE;
        end
        else
        begin
            w = x[WGT_W-1:0];
        end
        return w;
    endfunction

endpackage

@@ design/kti_ram.sv @@
// ----------------------------------------------------------------------------
// Keyframe interpolator RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/keyframe_track_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// Keyframe track interpolator
// Keyframe store per element and property, with eased interpolation queries.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset the block zeroes the key count of
// every track (MAX_ELEMENTS * PROPERTIES, 288 by default) with in_ready low.
// Clear and append read the key count, then write the update. A query reads
// its key count, then walks the track through the key memory read port,
// reading and then checking each key (up to MAX_KEYS keys, and the last key
// once more when it wraps back to it), then runs a divider that yields one
// quotient bit per cycle for a 34-bit quotient and a shift-and-add multiplier
// that takes one multiplier bit per cycle until the rest are zero, first for
// the easing square on eased keys and then for the blend. A query that
// returns a held key skips the divider and multiplier, and a query on an
// empty or out-of-range track also skips the key walk. A result waits in the
// output register while the next transaction is taken.
module keyframe_track_interpolator_unit #(
    parameter int MAX_ELEMENTS = 32,
    parameter int PROPERTIES   = 9,
    parameter int MAX_KEYS     = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  kti_pkg::in_item_t                     in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output kti_pkg::out_item_t                    out_data,
    input  logic                                  cfg_we,
    input  logic [kti_pkg::CFG_IX_W-1:0]          cfg_index,
    input  logic [kti_pkg::CFG_W-1:0]             cfg_data
);

    localparam int TRACKS  = MAX_ELEMENTS * PROPERTIES;
    localparam int TR_W    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int KDEPTH  = TRACKS * MAX_KEYS;
    localparam int KEY_AW  = $clog2(KDEPTH);
    localparam int IDX_W   = $clog2(MAX_KEYS);
    localparam int CNT_W   = $clog2(MAX_KEYS + 1);
    localparam int KEY_W   = $bits(kti_pkg::key_t);
    localparam int NUM_W   = 34;
    localparam int DEN_W   = 17;
    localparam int DCNT_W  = 6;
    localparam int MUL_W   = 53;
    localparam int MB_W    = 20;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CNT,
        S_RD,
        S_SCAN,
        S_WRAPRD,
        S_WRAPCHK,
        S_PREP,
        S_DIV,
        S_SAT,
        S_MUL,
        S_OUT
    } state_t;

    state_t                 state_reg,       state_next;
    kti_pkg::op_t           op_reg,          op_next;
    logic                   ok_reg,          ok_next;
    logic [TR_W-1:0]        tr_reg,          tr_next;
    kti_pkg::key_t          newkey_reg,      newkey_next;
    logic [kti_pkg::POS_W-1:0] pos_reg,      pos_next;
    logic [CNT_W-1:0]       n_reg,           n_next;
    logic [IDX_W-1:0]       i_reg,           i_next;
    kti_pkg::key_t          k0_reg,          k0_next;
    kti_pkg::key_t          prv_reg,         prv_next;
    kti_pkg::key_t          cur_reg,         cur_next;
    logic                   wrap_reg,        wrap_next;
    logic                   base_sub_reg,    base_sub_next;
    logic [NUM_W-1:0]       div_num_reg,     div_num_next;
    logic [DEN_W-1:0]       div_rem_reg,     div_rem_next;
    logic [DEN_W-1:0]       div_den_reg,     div_den_next;
    logic                   div_neg_reg,     div_neg_next;
    logic [DCNT_W-1:0]      div_cnt_reg,     div_cnt_next;
    logic [MUL_W-1:0]       mul_a_reg,       mul_a_next;
    logic [MB_W-1:0]        mul_b_reg,       mul_b_next;
    logic [MUL_W-1:0]       mul_acc_reg,     mul_acc_next;
    logic                   mul_sq_reg,      mul_sq_next;
    logic signed [31:0]     res_val_reg,     res_val_next;
    logic                   res_ok_reg,      res_ok_next;
    logic                   out_valid_reg,   out_valid_next;
    kti_pkg::out_item_t     out_data_reg,    out_data_next;
    logic [15:0]            cycle_len_reg,   cycle_len_next;
    logic                   loop_en_reg,     loop_en_next;

    // Memory ports
    logic                   key_we;
    logic [KEY_AW-1:0]      key_waddr;
    logic                   key_re;
    logic [KEY_AW-1:0]      key_raddr;
    logic [KEY_W-1:0]       key_rdata;
    logic [KEY_AW-1:0]      key_base;
    logic                   cnt_we;
    logic [CNT_W-1:0]       cnt_wdata;
    logic                   cnt_re;
    logic [TR_W-1:0]        cnt_raddr;
    logic [CNT_W-1:0]       cnt_rdata;

    // Datapath temporaries
    kti_pkg::key_t          rd_key;
    logic                   in_ok;
    logic [CNT_W-1:0]       cnt_cur;
    logic                   hit;
    logic                   last_key;
    logic signed [17:0]     pf;
    logic signed [17:0]     cf;
    logic signed [17:0]     lf;
    logic signed [17:0]     base_s;
    logic signed [17:0]     gap_s;
    logic signed [17:0]     gap_neg;
    logic signed [26:0]     rel_s;
    logic signed [26:0]     rel_neg;
    logic [17:0]            rem_sh;
    logic [17:0]            rem_dif;
    logic                   rem_ge;
    logic signed [19:0]     perc;
    logic signed [19:0]     ease_x;
    logic signed [19:0]     ease_xn;
    logic [18:0]            ease_mag;
    logic [20:0]            sq_sh;
    logic signed [kti_pkg::WRAW_W-1:0] w_raw;
    logic [kti_pkg::WGT_W-1:0] w_sel;
    logic                   load_blend;
    logic [32:0]            diff;
    logic [MUL_W-1:0]       blend_sum;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign rd_key  = kti_pkg::key_t'(key_rdata);
    assign in_ok   = (32'(in_data.element) < MAX_ELEMENTS) &&
                     (32'(in_data.property_req) < PROPERTIES);
    assign cnt_cur = cnt_rdata;

    // Address the key count and key memories
    assign cnt_re    = in_valid && in_ready;
    assign cnt_raddr = in_ok ? TR_W'(32'(in_data.element) * PROPERTIES +
                                     32'(in_data.property_req)) : '0;
    assign key_base  = KEY_AW'(32'(tr_reg) * MAX_KEYS);
    assign key_raddr = key_base + KEY_AW'(i_reg);
    assign key_waddr = key_base + KEY_AW'(cnt_cur[IDX_W-1:0]);
    assign key_re    = (state_reg == S_RD) || (state_reg == S_WRAPRD);
    assign key_we    = (state_reg == S_CNT) && (op_reg == kti_pkg::OP_APPEND) &&
                       ok_reg && (cnt_cur < CNT_W'(MAX_KEYS));
    // Zero a count while clearing after reset or on a clear, bump it on an append to a track that is not full
    assign cnt_we    = key_we || (state_reg == S_INIT) ||
                       ((state_reg == S_CNT) && (op_reg == kti_pkg::OP_CLEAR) && ok_reg);
    assign cnt_wdata = key_we ? cnt_cur + CNT_W'(1) : '0;

    // Scan compares
    assign hit      = {rd_key.frame, 8'h00} > pos_reg;
    assign last_key = (CNT_W'(i_reg) + CNT_W'(1)) == n_reg;

    // Interval set-up arithmetic
    assign pf      = signed'({2'b00, prv_reg.frame});
    assign cf      = signed'({2'b00, cur_reg.frame});
    assign lf      = signed'({2'b00, cycle_len_reg});
    assign base_s  = base_sub_reg ? pf - lf : pf;
    assign gap_s   = cf - pf + (wrap_reg ? lf : 18'sd0);
    assign gap_neg = -gap_s;
    assign rel_s   = signed'({3'b000, pos_reg}) - signed'({base_s[17], base_s, 8'h00});
    assign rel_neg = -rel_s;

    // Divider step
    assign rem_sh  = {div_rem_reg, div_num_reg[NUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, div_den_reg};
    assign rem_dif = rem_sh - {1'b0, div_den_reg};

    // Weight before easing, saturated to four units either side
    always_comb
    begin
        if (!div_neg_reg)
        begin
            perc = (div_num_reg > 34'd327680) ? -20'sd262144
                 : 20'sd65536 - signed'({1'b0, div_num_reg[18:0]});
        end
        else
        begin
            perc = (div_num_reg > 34'd196608) ? 20'sd262144
                 : 20'sd65536 + signed'({1'b0, div_num_reg[18:0]});
        end
    end

    assign ease_x   = (prv_reg.ease == kti_pkg::EASE_OUT) ? 20'sd65536 - perc : perc;
    assign ease_xn  = -ease_x;
    assign ease_mag = ease_x[19] ? ease_xn[18:0] : ease_x[18:0];
    assign sq_sh    = mul_acc_reg[36:16];
    assign w_raw    = (prv_reg.ease == kti_pkg::EASE_IN) ? signed'({2'b00, sq_sh})
                    : 23'sd65536 - signed'({2'b00, sq_sh});
    assign diff      = {prv_reg.val[31], prv_reg.val} - {cur_reg.val[31], cur_reg.val};
    assign blend_sum = mul_acc_reg + {{5{cur_reg.val[31]}}, cur_reg.val, 16'h0000} +
                       53'd32768;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ok_next        = ok_reg;
        tr_next        = tr_reg;
        newkey_next    = newkey_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        k0_next        = k0_reg;
        prv_next       = prv_reg;
        cur_next       = cur_reg;
        wrap_next      = wrap_reg;
        base_sub_next  = base_sub_reg;
        div_num_next   = div_num_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_neg_next   = div_neg_reg;
        div_cnt_next   = div_cnt_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_acc_next   = mul_acc_reg;
        mul_sq_next    = mul_sq_reg;
        res_val_next   = res_val_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        cycle_len_next = cycle_len_reg;
        loop_en_next   = loop_en_reg;
        w_sel          = kti_pkg::WGT_ONE;
        load_blend     = 1'b0;

        // Take configuration writes
        if (cfg_we)
        begin
            unique case (kti_pkg::cfg_reg_t'(cfg_index))
                kti_pkg::REG_CYCLE_LENGTH: cycle_len_next = cfg_data;
                kti_pkg::REG_LOOP_ENABLE:  loop_en_next   = cfg_data[0];
            endcase
        end

        unique case (state_reg)
            S_INIT:
            begin
                // Zero one key count per cycle
                tr_next = tr_reg + TR_W'(1);
                if (tr_reg == TR_W'(TRACKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                // Capture the transaction
                if (in_valid)
                begin
                    op_next     = in_data.op;
                    ok_next     = in_ok;
                    tr_next     = cnt_raddr;
                    newkey_next = '{val: in_data.key_value, frame: in_data.key_frame,
                                    ease: in_data.key_ease};
                    pos_next    = in_data.position;
                    state_next  = S_CNT;
                end
            end

            S_CNT:
            begin
                n_next       = cnt_cur;
                i_next       = '0;
                res_val_next = '0;
                res_ok_next  = 1'b0;
                state_next   = S_IDLE;
                unique case (op_reg)
                    kti_pkg::OP_CLEAR,
                    kti_pkg::OP_APPEND:
                    begin
                        // Count and key writes go out on the memory ports
                        state_next = S_IDLE;
                    end
                    kti_pkg::OP_QUERY:
                    begin
                        state_next = (ok_reg && cnt_cur != '0) ? S_RD : S_OUT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_RD:
            begin
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // Find the first key past the position
                if (i_reg == '0)
                begin
                    k0_next = rd_key;
                end
                if (hit)
                begin
                    cur_next = rd_key;
                    if (i_reg == '0)
                    begin
                        if (!loop_en_reg)
                        begin
                            res_val_next = rd_key.val;
                            res_ok_next  = 1'b1;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            i_next        = IDX_W'(n_reg - CNT_W'(1));
                            wrap_next     = 1'b1;
                            base_sub_next = 1'b1;
                            state_next    = S_WRAPRD;
                        end
                    end
                    else
                    begin
                        wrap_next     = 1'b0;
                        base_sub_next = 1'b0;
                        state_next    = S_PREP;
                    end
                end
                else
                begin
                    prv_next = rd_key;
                    if (last_key)
                    begin
                        if (!loop_en_reg)
                        begin
                            res_val_next = rd_key.val;
                            res_ok_next  = 1'b1;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            cur_next      = (i_reg == '0) ? rd_key : k0_reg;
                            wrap_next     = 1'b1;
                            base_sub_next = 1'b0;
                            state_next    = S_PREP;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = S_RD;
                    end
                end
            end

            S_WRAPRD:
            begin
                state_next = S_WRAPCHK;
            end

            S_WRAPCHK:
            begin
                prv_next   = rd_key;
                state_next = S_PREP;
            end

            S_PREP:
            begin
                // Hand the distance and gap to the divider
                if (gap_s == 18'sd0)
                begin
                    res_val_next = cur_reg.val;
                    res_ok_next  = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    div_num_next = {(rel_s[26] ? rel_neg[25:0] : rel_s[25:0]), 8'h00};
                    div_den_next = gap_s[17] ? gap_neg[DEN_W-1:0] : gap_s[DEN_W-1:0];
                    div_neg_next = rel_s[26] ^ gap_s[17];
                    div_rem_next = '0;
                    div_cnt_next = DCNT_W'(NUM_W);
                    state_next   = S_DIV;
                end
            end

            S_DIV:
            begin
                // One quotient bit per cycle
                div_rem_next = rem_ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                div_num_next = {div_num_reg[NUM_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(1))
                begin
                    state_next = S_SAT;
                end
            end

            S_SAT:
            begin
                unique case (prv_reg.ease)
                    kti_pkg::EASE_LINEAR:
                    begin
                        w_sel      = kti_pkg::clamp_weight({{3{perc[19]}}, perc});
                        load_blend = 1'b1;
                    end
                    kti_pkg::EASE_HOLD:
                    begin
                        w_sel      = kti_pkg::WGT_ONE;
                        load_blend = 1'b1;
                    end
                    kti_pkg::EASE_IN,
                    kti_pkg::EASE_OUT:
                    begin
                        mul_a_next   = MUL_W'(ease_mag);
                        mul_b_next   = MB_W'(ease_mag);
                        mul_acc_next = '0;
                        mul_sq_next  = 1'b1;
                    end
                endcase
                state_next = S_MUL;
            end

            S_MUL:
            begin
                // Shift and add, one multiplier bit per cycle
                if (mul_b_reg != '0)
                begin
                    if (mul_b_reg[0])
                    begin
                        mul_acc_next = mul_acc_reg + mul_a_reg;
                    end
                    mul_a_next = {mul_a_reg[MUL_W-2:0], 1'b0};
                    mul_b_next = {1'b0, mul_b_reg[MB_W-1:1]};
                end
                else if (mul_sq_reg)
                begin
                    w_sel      = kti_pkg::clamp_weight(w_raw);
                    load_blend = 1'b1;
                end
                else
                begin
                    res_val_next = blend_sum[47:16];
                    res_ok_next  = 1'b1;
                    state_next   = S_OUT;
                end
            end

            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{value: res_val_reg, valid_res: res_ok_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load the blend product: (prev - next) * weight
        if (load_blend)
        begin
            mul_a_next   = {{20{diff[32]}}, diff};
            mul_b_next   = MB_W'(w_sel);
            mul_acc_next = '0;
            mul_sq_next  = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            op_reg        <= kti_pkg::OP_CLEAR;
            ok_reg        <= 1'b0;
            tr_reg        <= '0;
            newkey_reg    <= '0;
            pos_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            k0_reg        <= '0;
            prv_reg       <= '0;
            cur_reg       <= '0;
            wrap_reg      <= 1'b0;
            base_sub_reg  <= 1'b0;
            div_num_reg   <= '0;
            div_rem_reg   <= '0;
            div_den_reg   <= '0;
            div_neg_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_acc_reg   <= '0;
            mul_sq_reg    <= 1'b0;
            res_val_reg   <= '0;
            res_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            cycle_len_reg <= 16'd50;
            loop_en_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ok_reg        <= ok_next;
            tr_reg        <= tr_next;
            newkey_reg    <= newkey_next;
            pos_reg       <= pos_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            k0_reg        <= k0_next;
            prv_reg       <= prv_next;
            cur_reg       <= cur_next;
            wrap_reg      <= wrap_next;
            base_sub_reg  <= base_sub_next;
            div_num_reg   <= div_num_next;
            div_rem_reg   <= div_rem_next;
            div_den_reg   <= div_den_next;
            div_neg_reg   <= div_neg_next;
            div_cnt_reg   <= div_cnt_next;
            mul_a_reg     <= mul_a_next;
            mul_b_reg     <= mul_b_next;
            mul_acc_reg   <= mul_acc_next;
            mul_sq_reg    <= mul_sq_next;
            res_val_reg   <= res_val_next;
            res_ok_reg    <= res_ok_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            cycle_len_reg <= cycle_len_next;
            loop_en_reg   <= loop_en_next;
        end
    end

    // Key store: value, frame and ease per key
    kti_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KDEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (newkey_reg),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // Key count per track
    kti_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TRACKS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (tr_reg),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

`ifndef SYNTH
    // The divider never runs on a zero gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_den_reg != '0))
        else $error("divider started with a zero divisor");

    // The scan stays inside the track
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(i_reg) < n_reg))
        else $error("key scan ran past the track's key count");

    // The blend weight never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && !mul_sq_reg) |-> (mul_b_reg <= MB_W'(kti_pkg::WGT_ONE)))
        else $error("blend weight out of range");
`endif

endmodule
